// ===== design/ata_pkg.sv =====
`default_nettype none
package ata_pkg;

    localparam int DEF_STAGES    = 16;
    localparam int DEF_FRAC_BITS = 8;
    localparam int TBL_LEN       = 24;
    localparam int ACC_Q         = 20;
    localparam int PRESCALE_SH   = 16;
    localparam int INV_GAIN_Q16  = 39797;
    localparam int DIFF_W        = 17;
    localparam int CW            = 38;
    localparam int ZW            = 32;
    localparam int OUT_W         = 16;

    localparam logic [1:0] REG_OFFSET_X = 2'd0;
    localparam logic [1:0] REG_OFFSET_Y = 2'd1;
    localparam logic [1:0] REG_OFFSET_Z = 2'd2;

    // side data that travels with each channel through the cells
    typedef struct packed {
        logic                     vld;
        logic signed [DIFF_W-1:0] num;
        logic                     num_zero;
        logic                     den_zero;
    } t_tag;

    // atan(2^-i) in degrees, 20 fraction bits
    function automatic logic signed [ZW-1:0] atan_q20(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:  v = 32'sd47185920;
            1:  v = 32'sd27855475;
            2:  v = 32'sd14718068;
            3:  v = 32'sd7471121;
            4:  v = 32'sd3750058;
            5:  v = 32'sd1876857;
            6:  v = 32'sd938658;
            7:  v = 32'sd469357;
            8:  v = 32'sd234682;
            9:  v = 32'sd117342;
            10: v = 32'sd58671;
            11: v = 32'sd29335;
            12: v = 32'sd14668;
            13: v = 32'sd7334;
            14: v = 32'sd3667;
            15: v = 32'sd1833;
            16: v = 32'sd917;
            17: v = 32'sd458;
            18: v = 32'sd229;
            19: v = 32'sd115;
            20: v = 32'sd57;
            21: v = 32'sd29;
            22: v = 32'sd14;
            23: v = 32'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== design/ata_if.sv =====
`default_nettype none
interface ata_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    modport source (output valid, accel_x, accel_y, accel_z, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface ata_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
    modport source (output valid, pitch_angle, roll_angle, input ready);
    modport sink   (input valid, pitch_angle, roll_angle, output ready);
endinterface
`default_nettype wire

// ===== design/ata_mag_cell.sv =====
`default_nettype none
module ata_mag_cell #(
    parameter int STAGE = 0
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic signed [ata_pkg::CW-1:0] i_x,
    input  wire logic signed [ata_pkg::CW-1:0] i_y,
    input  wire ata_pkg::t_tag                i_tag,
    output logic signed [ata_pkg::CW-1:0]      o_x,
    output logic signed [ata_pkg::CW-1:0]      o_y,
    output ata_pkg::t_tag                      o_tag
);
    logic signed [ata_pkg::CW-1:0] xs, ys, n_x, n_y;
    logic signed [ata_pkg::CW-1:0] r_x, r_y;
    ata_pkg::t_tag                 r_tag;

    always_comb begin
        xs = i_x >>> STAGE;
        ys = i_y >>> STAGE;
        if (!i_y[ata_pkg::CW-1]) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.vld <= 1'b0;
        end else if (i_en) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_tag <= i_tag;
        end
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_tag = r_tag;
endmodule
`default_nettype wire

// ===== design/ata_ang_cell.sv =====
`default_nettype none
module ata_ang_cell #(
    parameter int STAGE = 0
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic signed [ata_pkg::CW-1:0] i_x,
    input  wire logic signed [ata_pkg::CW-1:0] i_y,
    input  wire logic signed [ata_pkg::ZW-1:0] i_z,
    input  wire ata_pkg::t_tag                i_tag,
    output logic signed [ata_pkg::CW-1:0]      o_x,
    output logic signed [ata_pkg::CW-1:0]      o_y,
    output logic signed [ata_pkg::ZW-1:0]      o_z,
    output ata_pkg::t_tag                      o_tag
);
    localparam logic signed [ata_pkg::ZW-1:0] ATAN = ata_pkg::atan_q20(STAGE);

    logic signed [ata_pkg::CW-1:0] xs, ys, n_x, n_y;
    logic signed [ata_pkg::ZW-1:0] n_z;
    logic signed [ata_pkg::CW-1:0] r_x, r_y;
    logic signed [ata_pkg::ZW-1:0] r_z;
    ata_pkg::t_tag                 r_tag;

    always_comb begin
        xs = i_x >>> STAGE;
        ys = i_y >>> STAGE;
        if (!i_y[ata_pkg::CW-1]) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + ATAN;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.vld <= 1'b0;
        end else if (i_en) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_tag <= i_tag;
        end
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;
    assign o_tag = r_tag;
endmodule
`default_nettype wire

// ===== design/accel_tilt_angles_unit.sv =====
`default_nettype none
// Channel   Dir  Handshake     Payload
// i_smp     in   valid/ready   accel_x, accel_y, accel_z (16-bit signed)
// o_ang     out  valid/ready   pitch_angle, roll_angle (16-bit signed)
// i_cfg_*   in   write enable  offset_x/y/z at index 0/1/2
// One sample per clock while the output is not stalled; the path runs through the
// offset stage, the magnitude cells, the gain multiply, the angle cells and
// the output register. Reset clears all valid flags and the offsets.
// A stalled output holds the whole chain; input ready follows that stall.
module accel_tilt_angles_unit #(
    parameter int CORDIC_STAGES   = ata_pkg::DEF_STAGES,
    parameter int ANGLE_FRAC_BITS = ata_pkg::DEF_FRAC_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    ata_in_if.sink           i_smp,
    ata_out_if.source        o_ang
);
    localparam int CW  = ata_pkg::CW;
    localparam int ZW  = ata_pkg::ZW;
    localparam int DW  = ata_pkg::DIFF_W;
    localparam int SH  = ata_pkg::ACC_Q - ANGLE_FRAC_BITS;
    localparam int PW  = CW + DW;
    localparam logic signed [ZW-1:0] LIM  = ZW'(90) <<< ANGLE_FRAC_BITS;
    localparam logic signed [ZW-1:0] HALF = ZW'(1) <<< (SH - 1);
    localparam logic signed [DW-1:0] GAIN = DW'(ata_pkg::INV_GAIN_Q16);

    logic [15:0] r_off_x, r_off_y, r_off_z;
    logic        en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x <= '0;
            r_off_y <= '0;
            r_off_z <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ata_pkg::REG_OFFSET_X: r_off_x <= i_cfg_data;
                ata_pkg::REG_OFFSET_Y: r_off_y <= i_cfg_data;
                ata_pkg::REG_OFFSET_Z: r_off_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // offset subtract stage
    logic signed [DW-1:0] r_dx, r_dy, r_dz;
    logic                 r_d_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (en) begin
            r_d_vld <= i_smp.valid;
            r_dx <= {i_smp.accel_x[15], i_smp.accel_x} - {r_off_x[15], r_off_x};
            r_dy <= {i_smp.accel_y[15], i_smp.accel_y} - {r_off_y[15], r_off_y};
            r_dz <= {i_smp.accel_z[15], i_smp.accel_z} - {r_off_z[15], r_off_z};
        end
    end

    logic signed [1:0][15:0] ang;
    logic [1:0]              ang_vld;

    genvar c, s;
    generate
        for (c = 0; c < 2; c++) begin : g_ch
            // channel 0: pitch (num dy, den dx,dz); channel 1: roll (num dx, den dy,dz)
            logic signed [DW-1:0] num, den_a;
            logic signed [DW:0]   a_ext, a_abs;
            logic signed [CW-1:0] mx [0:CORDIC_STAGES];
            logic signed [CW-1:0] my [0:CORDIC_STAGES];
            ata_pkg::t_tag        mt [0:CORDIC_STAGES];
            logic signed [CW-1:0] ax [0:CORDIC_STAGES];
            logic signed [CW-1:0] ay [0:CORDIC_STAGES];
            logic signed [ZW-1:0] az [0:CORDIC_STAGES];
            ata_pkg::t_tag        at [0:CORDIC_STAGES];
            logic signed [PW-1:0] prod;
            logic signed [CW-1:0] r_mag;
            ata_pkg::t_tag        r_mtag;
            logic signed [ZW-1:0] rnd, clp;

            assign num   = (c == 0) ? r_dy : r_dx;
            assign den_a = (c == 0) ? r_dx : r_dy;
            assign a_ext = {den_a[DW-1], den_a};
            assign a_abs = den_a[DW-1] ? -a_ext : a_ext;

            always_comb begin
                mx[0] = CW'(a_abs) <<< ata_pkg::PRESCALE_SH;
                my[0] = CW'(r_dz) <<< ata_pkg::PRESCALE_SH;
                mt[0].vld      = r_d_vld;
                mt[0].num      = num;
                mt[0].num_zero = (num == '0);
                mt[0].den_zero = (den_a == '0) && (r_dz == '0);
            end

            for (s = 0; s < CORDIC_STAGES; s++) begin : g_mag
                ata_mag_cell #(.STAGE(s)) u_cell (
                    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
                    .i_x(mx[s]), .i_y(my[s]), .i_tag(mt[s]),
                    .o_x(mx[s+1]), .o_y(my[s+1]), .o_tag(mt[s+1])
                );
            end

            // gain correction, floor shift
            assign prod = mx[CORDIC_STAGES] * GAIN;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_mtag.vld <= 1'b0;
                end else if (en) begin
                    r_mag  <= prod[CW+15:16];
                    r_mtag <= mt[CORDIC_STAGES];
                end
            end

            assign ax[0] = r_mag;
            assign ay[0] = CW'(r_mtag.num) <<< ata_pkg::PRESCALE_SH;
            assign az[0] = '0;
            assign at[0] = r_mtag;

            for (s = 0; s < CORDIC_STAGES; s++) begin : g_ang
                ata_ang_cell #(.STAGE(s)) u_cell (
                    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
                    .i_x(ax[s]), .i_y(ay[s]), .i_z(az[s]), .i_tag(at[s]),
                    .o_x(ax[s+1]), .o_y(ay[s+1]), .o_z(az[s+1]), .o_tag(at[s+1])
                );
            end

            always_comb begin
                rnd = (az[CORDIC_STAGES] + HALF) >>> SH;
                if (rnd > LIM) begin
                    clp = LIM;
                end else if (rnd < -LIM) begin
                    clp = -LIM;
                end else begin
                    clp = rnd;
                end
                if (at[CORDIC_STAGES].num_zero) begin
                    ang[c] = '0;
                end else if (at[CORDIC_STAGES].den_zero) begin
                    ang[c] = at[CORDIC_STAGES].num[DW-1] ? 16'(-LIM) : 16'(LIM);
                end else begin
                    ang[c] = clp[15:0];
                end
            end
            assign ang_vld[c] = at[CORDIC_STAGES].vld;
        end
    endgenerate

    logic               r_out_vld;
    logic signed [15:0] r_pitch, r_roll;

    assign en = !r_out_vld || o_ang.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= ang_vld[0] & ang_vld[1];
            r_pitch   <= ang[0];
            r_roll    <= ang[1];
        end
    end

    assign i_smp.ready       = en;
    assign o_ang.valid       = r_out_vld;
    assign o_ang.pitch_angle = r_pitch;
    assign o_ang.roll_angle  = r_roll;
endmodule
`default_nettype wire
